>>> hdl/scpa_pkg.sv
// Shared codes, class size table and control types of the size class pool allocator.
package scpa_pkg;

  localparam int FIELD_W  = 15;
  localparam int TAG_W    = 4;
  localparam int BGRAN_W  = 10;
  localparam int MAX_CLS  = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_EXHAUST = 2'd3;

  // Payload bytes per class; unused classes have size 0 and never fit.
  localparam logic [FIELD_W-1:0] CLASS_SIZE [MAX_CLS] = '{
    15'd80,  15'd160, 15'd240, 15'd320, 15'd400, 15'd480, 15'd560, 15'd640,
    15'd720, 15'd1000, 15'd0,  15'd0,   15'd0,   15'd0,   15'd0,   15'd0
  };

  typedef struct packed {
    logic link_we;
    logic tag_we;
  } mem_wr_t;

endpackage

>>> hdl/scpa_class_sel.sv
// First-fit size class selection and block length lookup in granules.
module scpa_class_sel #(
  parameter int NUM_CLASSES  = 10,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 8
) (
  input  logic [scpa_pkg::FIELD_W-1:0] req,
  output logic                         found,
  output logic [scpa_pkg::TAG_W-1:0]   sel,
  output logic [scpa_pkg::BGRAN_W-1:0] blk_gran
);

  localparam int BW  = scpa_pkg::BGRAN_W;
  localparam int TW  = scpa_pkg::TAG_W;
  localparam int CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [BW-1:0] gran_tab [NUM_CLASSES];

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_gran
    localparam int BG =
      (int'(scpa_pkg::CLASS_SIZE[c]) + HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    assign gran_tab[c] = BW'(BG);
  end

  // scan downward so the lowest fitting class wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (scpa_pkg::CLASS_SIZE[c] >= req) begin
        found = 1'b1;
        sel   = TW'(c);
      end
    end
  end

  assign blk_gran = gran_tab[sel[CIW-1:0]];

endmodule

>>> hdl/scpa_store.sv
// Per-granule link and class tag memories, one read and one write port each cycle.
module scpa_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int LW    = 13
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [LW-1:0]              rd_link,
  output logic [scpa_pkg::TAG_W-1:0] rd_tag,
  input  scpa_pkg::mem_wr_t          wr,
  input  logic [AW-1:0]              wr_addr,
  input  logic [LW-1:0]              link_wdata,
  input  logic [scpa_pkg::TAG_W-1:0] tag_wdata
);

  logic [LW-1:0]              link_mem [DEPTH];
  logic [scpa_pkg::TAG_W-1:0] tag_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
    if (wr.tag_we) begin
      tag_mem[wr_addr] <= tag_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_link <= link_mem[rd_addr];
      rd_tag  <= tag_mem[rd_addr];
    end
  end

endmodule

>>> hdl/size_class_pool_allocator_top.sv
// Top level of the size class pool allocator: control, list heads and carve pointer.
// Each item passes accept, decode with memory read and execute with write back,
// and its result is registered in the output register at the end of execute. No
// new item is accepted before the last is through (link and tag read-modify-write).
// A stalled output register holds the execute step until the result slot frees.
// Reset empties all free lists and zeroes the carve pointer; the
// link and tag memories are not cleared.
module size_class_pool_allocator_top #(
  parameter int HEAP_BYTES   = 32768,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 8,
  parameter int NUM_CLASSES  = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [scpa_pkg::FIELD_W-1:0] in_request_size,
  input  logic [scpa_pkg::FIELD_W-1:0] in_free_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [scpa_pkg::FIELD_W-1:0] out_address,
  output logic [scpa_pkg::TAG_W-1:0]   out_class_index
);

  localparam int FW       = scpa_pkg::FIELD_W;
  localparam int TW       = scpa_pkg::TAG_W;
  localparam int BW       = scpa_pkg::BGRAN_W;
  localparam int GRANULES = HEAP_BYTES / ALIGN_BYTES;
  localparam int GW       = (GRANULES > 1) ? $clog2(GRANULES) : 1;
  localparam int LW       = GW + 1;
  localparam int CW       = $clog2(GRANULES + 1);
  localparam int SW       = ((CW > BW) ? CW : BW) + 1;
  localparam int CIW      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int ADW      = GW + 8;
  // exact reciprocal for the granule quotient of a 15-bit offset
  localparam int RL       = $clog2(ALIGN_BYTES);
  localparam int RS       = FW + RL;
  localparam int RM       = ((1 << RS) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int PW       = 34;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_EXE  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic          cmd_r;
  logic [FW-1:0] req_r, fa_r;

  logic [GW-1:0] class_head_r       [NUM_CLASSES];
  logic [GW-1:0] class_head_nxt     [NUM_CLASSES];
  logic          class_head_valid_r   [NUM_CLASSES];
  logic          class_head_valid_nxt [NUM_CLASSES];
  logic [CW-1:0] carve_r, carve_nxt;

  // decode stage results
  logic          zero_r, found_r, free_ok_r;
  logic [TW-1:0] sel_r;
  logic [BW-1:0] bgran_r;
  logic [GW-1:0] fgran_r;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [FW-1:0] out_address_r, out_address_nxt;
  logic [TW-1:0] out_class_r, out_class_nxt;

  logic          dec_found;
  logic [TW-1:0] dec_sel;
  logic [BW-1:0] dec_bgran;
  logic [FW-1:0] fa_off;
  logic [PW-1:0] fa_prod;
  logic [FW-1:0] fa_quot;
  logic          dec_free_ok;

  logic          rd_en;
  logic [GW-1:0] rd_addr;
  logic [LW-1:0] rd_link;
  logic [TW-1:0] rd_tag;

  scpa_pkg::mem_wr_t wr;
  logic [GW-1:0] wr_addr;
  logic [LW-1:0] link_wdata;
  logic [TW-1:0] tag_wdata;

  logic          slot_free;
  logic [GW-1:0] addr_gran;
  logic [ADW-1:0] addr_full;
  logic [SW-1:0] carve_end;
  logic          pop_hit;

  scpa_class_sel #(
    .NUM_CLASSES (NUM_CLASSES),
    .ALIGN_BYTES (ALIGN_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_class_sel (
    .req     (req_r),
    .found   (dec_found),
    .sel     (dec_sel),
    .blk_gran(dec_bgran)
  );

  scpa_store #(
    .DEPTH(GRANULES),
    .AW   (GW),
    .LW   (LW)
  ) u_store (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_link   (rd_link),
    .rd_tag    (rd_tag),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .link_wdata(link_wdata),
    .tag_wdata (tag_wdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  // free address to granule index
  assign fa_off      = fa_r - FW'(HEADER_BYTES);
  assign fa_prod     = PW'(fa_off) * PW'(RM);
  assign fa_quot     = FW'(fa_prod >> RS);
  assign dec_free_ok = (32'(fa_r) >= 32'(HEADER_BYTES)) && (32'(fa_quot) < 32'(GRANULES));

  assign rd_en   = (state_r == S_DEC);
  assign rd_addr = (cmd_r == scpa_pkg::CMD_ALLOC) ? class_head_r[dec_sel[CIW-1:0]]
                                                  : GW'(fa_quot);

  assign pop_hit   = class_head_valid_r[sel_r[CIW-1:0]];
  assign carve_end = SW'(carve_r) + SW'(bgran_r);
  assign addr_gran = pop_hit ? class_head_r[sel_r[CIW-1:0]] : GW'(carve_r);
  assign addr_full = ADW'(addr_gran) * ADW'(ALIGN_BYTES) + ADW'(HEADER_BYTES);

  always_comb begin
    state_nxt            = state_r;
    class_head_nxt       = class_head_r;
    class_head_valid_nxt = class_head_valid_r;
    carve_nxt            = carve_r;
    out_valid_nxt        = out_valid_r && out_stall;
    out_status_nxt       = out_status_r;
    out_address_nxt      = out_address_r;
    out_class_nxt        = out_class_r;
    wr                   = '0;
    wr_addr              = fgran_r;
    link_wdata           = '0;
    tag_wdata            = sel_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_EXE;
      end
      S_EXE: begin
        if (slot_free) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = scpa_pkg::ST_OK;
          out_address_nxt = '0;
          out_class_nxt   = '0;
          if (cmd_r == scpa_pkg::CMD_ALLOC) begin
            if (zero_r) begin
              out_status_nxt = scpa_pkg::ST_ZERO;
            end else if (!found_r) begin
              out_status_nxt = scpa_pkg::ST_NOFIT;
            end else if (pop_hit) begin
              // pop the list head; its link gives the new head
              out_address_nxt = FW'(addr_full);
              out_class_nxt   = sel_r;
              if (rd_link != '0) begin
                class_head_nxt[sel_r[CIW-1:0]] = GW'(rd_link - LW'(1));
              end else begin
                class_head_nxt[sel_r[CIW-1:0]]       = '0;
                class_head_valid_nxt[sel_r[CIW-1:0]] = 1'b0;
              end
            end else if (carve_end > SW'(GRANULES)) begin
              out_status_nxt = scpa_pkg::ST_EXHAUST;
              out_class_nxt  = sel_r;
            end else begin
              // carve a fresh block and tag it
              wr.tag_we       = 1'b1;
              wr_addr         = GW'(carve_r);
              out_address_nxt = FW'(addr_full);
              out_class_nxt   = sel_r;
              carve_nxt       = CW'(carve_end);
            end
          end else if (free_ok_r && (32'(rd_tag) < 32'(NUM_CLASSES))) begin
            // push the block onto the list of its tagged class
            wr.link_we = 1'b1;
            link_wdata = class_head_valid_r[rd_tag[CIW-1:0]]
                         ? LW'(class_head_r[rd_tag[CIW-1:0]]) + LW'(1) : '0;
            class_head_nxt[rd_tag[CIW-1:0]]       = fgran_r;
            class_head_valid_nxt[rd_tag[CIW-1:0]] = 1'b1;
            out_class_nxt = rd_tag;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      carve_r     <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        class_head_r[c]       <= '0;
        class_head_valid_r[c] <= 1'b0;
      end
    end else begin
      state_r            <= state_nxt;
      carve_r            <= carve_nxt;
      out_valid_r        <= out_valid_nxt;
      class_head_r       <= class_head_nxt;
      class_head_valid_r <= class_head_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_cmd;
      req_r <= in_request_size;
      fa_r  <= in_free_address;
    end
    if (state_r == S_DEC) begin
      zero_r    <= (req_r == '0);
      found_r   <= dec_found;
      sel_r     <= dec_sel;
      bgran_r   <= dec_bgran;
      free_ok_r <= dec_free_ok;
      fgran_r   <= GW'(fa_quot);
    end
    out_status_r  <= out_status_nxt;
    out_address_r <= out_address_nxt;
    out_class_r   <= out_class_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_address     = out_address_r;
  assign out_class_index = out_class_r;

endmodule

>>> hdl/scpa_checker.sv
// Port-level checker for the size class pool allocator and its bind to the top level.
module scpa_checker #(
  parameter int NUM_CLASSES = 10
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   out_status,
  input logic [scpa_pkg::FIELD_W-1:0] out_address,
  input logic [scpa_pkg::TAG_W-1:0]   out_class_index
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_address) && $stable(out_status)
                               && $stable(out_class_index))
    else $error("stalled result changed");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != scpa_pkg::ST_OK |-> out_address == '0)
    else $error("failed request carries an address");

  a_fail_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == scpa_pkg::ST_ZERO || out_status == scpa_pkg::ST_NOFIT)
    |-> out_class_index == '0)
    else $error("rejected request carries a class");

  a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_class_index) < 32'(NUM_CLASSES))
    else $error("class index out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind size_class_pool_allocator_top scpa_checker #(
  .NUM_CLASSES(NUM_CLASSES)
) u_scpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_address    (out_address),
  .out_class_index(out_class_index)
);
